[rtl/circular_deque_core_defines.svh]
// Assertion macros for the circular deque core.
// Used by the top level only; no other dependencies.
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off during rst
`define CDQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CDQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/cdq_pkg.sv]
// Shared constants, command/status codes and control structs for the deque.
// No dependencies.
`default_nettype none

package cdq_pkg;

  // Store geometry
  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Item field widths
  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  // Stream data widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((CMD_W + WORD_W + 7) / 8) * 8;
  localparam int OUT_BITS    = STAT_W + WORD_W + OCC_W + 2;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    update;     // apply op to indices, count and store
    cmd_t    op;
    logic    load_out;   // capture result register
    logic    use_rdata;  // popped word comes from the store read port
    status_t status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/cdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cdq_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/cdq_ctrl.sv]
// Controller for the deque: handshake, command legality and result sequencing.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire cmd_t     cmd,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       dp_cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;
  logic   accept;
  logic   is_push;
  logic   legal;

  // take an item only when the result register will be free
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
  assign legal    = is_push ? !stat.full : !stat.empty;

  // command decode and next state
  always_comb begin
    state_next        = state;
    dp_cmd.update     = 1'b0;
    dp_cmd.op         = cmd;
    dp_cmd.load_out   = 1'b0;
    dp_cmd.use_rdata  = 1'b0;
    dp_cmd.status     = ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          dp_cmd.update = legal;
          if (is_push || !legal) begin
            dp_cmd.load_out = 1'b1;
            if (!legal) begin
              dp_cmd.status = is_push ? ST_OVERFLOW : ST_UNDERFLOW;
            end
          end else begin
            // successful pop: wait in S_READ for the store read
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        dp_cmd.load_out  = 1'b1;
        dp_cmd.use_rdata = 1'b1;
        state_next       = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    priority if (dp_cmd.load_out) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

[rtl/cdq_dpath.sv]
// Datapath for the deque: head/tail indices, word count, word store, result register.
// Depends on cdq_pkg and cdq_ram.
`default_nettype none

module cdq_dpath import cdq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  dp_cmd,
  input  wire logic signed [WORD_W-1:0] push_value,
  output dp_stat_t                      stat,
  output status_t                       status,
  output logic signed [WORD_W-1:0]      popped_value,
  output logic [OCC_W-1:0]              occupancy,
  output logic                          is_empty,
  output logic                          is_full
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [IDX_W-1:0] head, head_next, tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] rdata;

  // wrapping index steps
  assign head_inc = (head == IDX_LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? IDX_LAST : head - 1'b1;
  assign tail_inc = (tail == IDX_LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? IDX_LAST : tail - 1'b1;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_FULL);

  // read address is presented on the accepting edge
  assign raddr = (dp_cmd.op == CMD_POP_BACK) ? tail_dec : head;

  // index, count and write update
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    we         = 1'b0;
    waddr      = tail;
    if (dp_cmd.update) begin
      unique case (dp_cmd.op)
        CMD_PUSH_FRONT: begin
          head_next  = head_dec;
          waddr      = head_dec;
          we         = 1'b1;
          count_next = count + 1'b1;
        end
        CMD_PUSH_BACK: begin
          tail_next  = tail_inc;
          we         = 1'b1;
          count_next = count + 1'b1;
        end
        CMD_POP_FRONT: begin
          head_next  = head_inc;
          count_next = count - 1'b1;
        end
        CMD_POP_BACK: begin
          tail_next  = tail_dec;
          count_next = count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result register, no reset needed on payload
  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      status       <= dp_cmd.status;
      popped_value <= dp_cmd.use_rdata ? signed'(rdata) : '0;
      occupancy    <= OCC_W'(count_next);
      is_empty     <= (count_next == '0);
      is_full      <= (count_next == CNT_FULL);
    end
  end

endmodule

`default_nettype wire

[rtl/circular_deque_core.sv]
// Double-ended queue of signed 32-bit words held in an 8-entry circular store.
// Each input item is a command (push front, push back, pop front, pop back) and
// a word; each gives exactly one result item with a status (done, overflow,
// underflow), the popped word (zero unless a pop succeeded), the occupancy and
// empty/full flags after the command. A push, overflow or underflow result is
// registered on the accepting edge; a successful pop waits in S_READ for the
// store's registered read port. Results wait in an output register; outside
// S_READ a new item is taken in the cycle that register is emptied or already
// empty. Reset clears the indices and count; the store needs no clearing.
// Depends on cdq_pkg, cdq_ctrl, cdq_dpath, cdq_ram and the defines header.
`default_nettype none

`include "circular_deque_core_defines.svh"

module circular_deque_core import cdq_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // s_tdata: cmd[1:0], push_value[33:2], zero pad
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // m_tdata: status[1:0], popped_value[33:2], occupancy[37:34],
  //          is_empty[38], is_full[39]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  dp_cmd_t                   dp_cmd;
  dp_stat_t                  dp_stat;
  cmd_t                      cmd;
  logic signed [WORD_W-1:0]  push_value;
  status_t                   status;
  logic signed [WORD_W-1:0]  popped_value;
  logic [OCC_W-1:0]          occupancy;
  logic                      is_empty;
  logic                      is_full;

  // unpack input item
  assign cmd        = cmd_t'(s_tdata[CMD_W-1:0]);
  assign push_value = signed'(s_tdata[CMD_W +: WORD_W]);

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  cdq_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .push_value   (push_value),
    .stat         (dp_stat),
    .status       (status),
    .popped_value (popped_value),
    .occupancy    (occupancy),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

  // pack result item
  assign m_tdata = OUT_TDATA_W'({is_full, is_empty, occupancy, popped_value, status});

  // checks
  `CDQ_ASSERT_IMPLY(a_not_empty_and_full, 1'b1, !(dp_stat.empty && dp_stat.full), "deque both empty and full")
  `CDQ_ASSERT_IMPLY(a_overflow_flags, m_tvalid && (status == ST_OVERFLOW), is_full && (popped_value == '0), "overflow result without full flag")
  `CDQ_ASSERT_IMPLY(a_underflow_flags, m_tvalid && (status == ST_UNDERFLOW), is_empty && (popped_value == '0), "underflow result without empty flag")
  `CDQ_ASSERT_NEXT(a_pop_waits_read, s_tvalid && s_tready && !dp_stat.empty && ((cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK)), !s_tready && !m_tvalid, "pop did not wait for store read")

endmodule

`default_nettype wire
